[hdl/ajrs_pkg.sv]
package ajrs_pkg;

  // Word formats
  localparam int ANGLE_BITS     = 16;
  localparam int RATE_FRAC_BITS = 16;
  localparam int ANG_W          = 16;
  localparam int LEN_W          = 16;
  localparam int VEL_W          = 16;
  localparam int RATE_W         = 32;
  localparam int CFG_IDX_W      = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOOL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd3;

  // Register reset values
  localparam logic [LEN_W-1:0] UPPER_RST = 16'd2074;
  localparam logic [LEN_W-1:0] FORE_RST  = 16'd2074;
  localparam logic [LEN_W-1:0] TOOL_RST  = 16'd1613;
  localparam logic [LEN_W-1:0] BASE_RST  = 16'd461;

  // CORDIC
  localparam int ATAN_COUNT   = 24;
  localparam int CORDIC_ITERS = (ANGLE_BITS < ATAN_COUNT) ? ANGLE_BITS : ATAN_COUNT;
  localparam int CX_W         = 33;
  localparam int CZ_W         = 34;
  localparam int TRIG_W       = CX_W - 14;
  localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
  localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
  localparam logic signed [CX_W-1:0] CORDIC_K = 33'sd652032874;

  // Jacobian and solve widths
  localparam int LT_W   = LEN_W + 1 + TRIG_W;
  localparam int TT_W   = 2 * TRIG_W;
  localparam int LTT_W  = LEN_W + 1 + TT_W;
  localparam int R_W    = 20;
  localparam int A_W    = 20;
  localparam int TR_W   = TRIG_W + R_W;
  localparam int COF_W  = 2 * A_W + 1;
  localparam int DP_W   = A_W + COF_W;
  localparam int DET_W  = DP_W + 2;
  localparam int NP_W   = COF_W + VEL_W;
  localparam int NUM_W  = NP_W + 2;

  // Divider
  localparam int QUO_W   = RATE_W;
  localparam int NSH_W   = NUM_W + RATE_FRAC_BITS;
  localparam int HI_W    = NSH_W - QUO_W;
  localparam int CMP_W   = (HI_W > DET_W) ? HI_W : DET_W;
  localparam int DIV_LAT = QUO_W + 3;

  // Whole pipe
  localparam int VD_LEN   = CORDIC_LAT + 4;
  localparam int PIPE_LEN = CORDIC_LAT + 6 + DIV_LAT;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/ajrs_cordic.sv]
module ajrs_cordic import ajrs_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ANG_W-1:0]         ang,
  output logic signed [TRIG_W-1:0] sin_val,
  output logic signed [TRIG_W-1:0] cos_val
);

  logic signed [CX_W-1:0] x [0:CORDIC_ITERS];
  logic signed [CX_W-1:0] y [0:CORDIC_ITERS];
  logic signed [CZ_W-1:0] z [0:CORDIC_ITERS];
  logic [CORDIC_ITERS:0]  flip;

  logic [31:0]            p_raw;
  logic [31:0]            p_rot;
  logic                   p_flip;
  logic signed [CX_W-1:0] xr;
  logic signed [CX_W-1:0] yr;
  logic signed [TRIG_W-1:0] xq;
  logic signed [TRIG_W-1:0] yq;

  // Fold the angle into the right half plane
  always_comb begin
    p_raw  = {ang, 16'h0000} & ANG_MASK;
    p_flip = p_raw[31] ^ p_raw[30];
    p_rot  = p_flip ? (p_raw ^ 32'h8000_0000) : p_raw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CORDIC_K;
      y[0]    <= '0;
      z[0]    <= {{(CZ_W-32){p_rot[31]}}, p_rot};
      flip[0] <= p_flip;
    end
  end

  // One rotation per stage
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [CZ_W-1:0] at;
    assign at = $signed({{(CZ_W-32){1'b0}}, atan_turn(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][CZ_W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - at;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + at;
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  // Round to Q1.15 and undo the fold
  always_comb begin
    xr = x[CORDIC_ITERS] + CX_W'(16384);
    yr = y[CORDIC_ITERS] + CX_W'(16384);
    xq = {xr[CX_W-1], xr[CX_W-1:15]};
    yq = {yr[CX_W-1], yr[CX_W-1:15]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= flip[CORDIC_ITERS] ? -xq : xq;
      sin_val <= flip[CORDIC_ITERS] ? -yq : yq;
    end
  end

endmodule

[hdl/ajrs_div.sv]
module ajrs_div import ajrs_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [NUM_W-1:0]  num,
  input  logic signed [DET_W-1:0]  den,
  output logic signed [RATE_W-1:0] quo,
  output logic                     sat
);

  logic             p_neg;
  logic [NUM_W-1:0] p_n;
  logic [DET_W-1:0] p_d;

  logic [DET_W-1:0] rem  [0:QUO_W];
  logic [DET_W-1:0] dv   [0:QUO_W];
  logic [QUO_W-1:0] lo   [0:QUO_W];
  logic [QUO_W-1:0] q    [0:QUO_W];
  logic [QUO_W:0]   neg;
  logic [QUO_W:0]   ovf;

  logic [NSH_W-1:0] n_sh;
  logic [CMP_W-1:0] hi_c;
  logic [CMP_W-1:0] d_c;
  logic [RATE_W:0]  lim;
  logic             over;
  logic [RATE_W-1:0] mag;

  // Take magnitudes and the result sign
  always_ff @(posedge clk) begin
    if (en) begin
      p_neg <= num[NUM_W-1] ^ den[DET_W-1];
      p_n   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      p_d   <= den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
    end
  end

  // Split the scaled dividend; an oversized high part means overflow
  always_comb begin
    n_sh = {p_n, {RATE_FRAC_BITS{1'b0}}};
    hi_c = CMP_W'(n_sh[NSH_W-1:QUO_W]);
    d_c  = CMP_W'(p_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= hi_c[DET_W-1:0];
      dv[0]  <= p_d;
      lo[0]  <= n_sh[QUO_W-1:0];
      q[0]   <= '0;
      neg[0] <= p_neg;
      ovf[0] <= (hi_c >= d_c);
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DET_W:0]   t;
    logic [DET_W+1:0] df;
    logic             ge;
    assign t  = {rem[k], lo[k][QUO_W-1]};
    assign df = {1'b0, t} - {2'b00, dv[k]};
    assign ge = !df[DET_W+1];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? df[DET_W-1:0] : t[DET_W-1:0];
        q[k+1]   <= {q[k][QUO_W-2:0], ge};
        lo[k+1]  <= {lo[k][QUO_W-2:0], 1'b0};
        dv[k+1]  <= dv[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  // Clip and apply the sign
  always_comb begin
    lim  = neg[QUO_W] ? ((RATE_W+1)'(1) << (RATE_W-1))
                      : (((RATE_W+1)'(1) << (RATE_W-1)) - (RATE_W+1)'(1));
    over = ovf[QUO_W] || ({1'b0, q[QUO_W]} > lim);
    mag  = over ? lim[RATE_W-1:0] : q[QUO_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[QUO_W] ? -$signed(mag) : $signed(mag);
      sat <= over;
    end
  end

endmodule

[hdl/arm_joint_rate_solver.sv]
// Channel  | handshake                  | word
// ---------+----------------------------+------------------------------------------
// input    | in_valid / in_stall        | three joint angles, tool velocity x, y, z
// output   | out_valid / out_stall      | three joint rates, singular, saturated
// config   | cfg_we, cfg_index          | cfg_data into one of four link registers
//
// One word enters per clock while no finished word is stalled at the output.
// Latency is set by the CORDIC rotation stages and the 32 quotient stages of the divider.
// The whole pipe advances together and holds while a finished word is stalled at the output.
// rst clears the valid bits and loads the link registers with their reset values.
module arm_joint_rate_solver import ajrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ANG_W-1:0]         base_angle,
  input  logic [ANG_W-1:0]         shoulder_angle,
  input  logic [ANG_W-1:0]         elbow_angle,
  input  logic signed [VEL_W-1:0]  vel_x,
  input  logic signed [VEL_W-1:0]  vel_y,
  input  logic signed [VEL_W-1:0]  vel_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [RATE_W-1:0] base_rate,
  output logic signed [RATE_W-1:0] shoulder_rate,
  output logic signed [RATE_W-1:0] elbow_rate,
  output logic                     singular,
  output logic                     saturated,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [LEN_W-1:0]         cfg_data
);

  logic [LEN_W-1:0] upper;
  logic [LEN_W-1:0] fore;
  logic [LEN_W-1:0] tool;
  logic [LEN_W-1:0] base;

  logic                en;
  logic [PIPE_LEN-1:0] vld;

  logic signed [TRIG_W-1:0] sb, cb, ss, cs, se, ce;
  logic signed [VEL_W-1:0]  vxd [0:VD_LEN-1];
  logic signed [VEL_W-1:0]  vyd [0:VD_LEN-1];
  logic signed [VEL_W-1:0]  vzd [0:VD_LEN-1];

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper <= UPPER_RST;
      fore  <= FORE_RST;
      tool  <= TOOL_RST;
      base  <= BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPPER: upper <= cfg_data;
        REG_FORE:  fore  <= cfg_data;
        REG_TOOL:  tool  <= cfg_data;
        REG_BASE:  base  <= cfg_data;
      endcase
    end
  end

  // Advance everything unless the output word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LEN-2:0], in_valid};
    end
  end

  // Sine and cosine of each joint
  ajrs_cordic u_cor_base (.clk(clk), .en(en), .ang(base_angle),
                          .sin_val(sb), .cos_val(cb));
  ajrs_cordic u_cor_shoulder (.clk(clk), .en(en), .ang(shoulder_angle),
                              .sin_val(ss), .cos_val(cs));
  ajrs_cordic u_cor_elbow (.clk(clk), .en(en), .ang(elbow_angle),
                           .sin_val(se), .cos_val(ce));

  // Carry the velocity alongside
  always_ff @(posedge clk) begin
    if (en) begin
      vxd[0] <= vel_x;
      vyd[0] <= vel_y;
      vzd[0] <= vel_z;
      for (int i = 1; i < VD_LEN; i++) begin
        vxd[i] <= vxd[i-1];
        vyd[i] <= vyd[i-1];
        vzd[i] <= vzd[i-1];
      end
    end
  end

  logic signed [LEN_W:0] a_s, b_s;
  assign a_s = $signed({1'b0, upper});
  assign b_s = $signed({1'b0, fore});

  // Stage 1: link projections and trig products
  logic signed [LT_W-1:0]   as_p, bc_p;
  logic signed [A_W-1:0]    as1, bc1;
  logic signed [TT_W-1:0]   cbcs1, sbcs1, cbse1, sbse1;
  logic signed [TRIG_W-1:0] sb1, cb1;

  always_comb begin
    as_p = a_s * ss + LT_W'(16384);
    bc_p = b_s * ce + LT_W'(16384);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      as1   <= A_W'(as_p >>> 15);
      bc1   <= A_W'(bc_p >>> 15);
      cbcs1 <= cb * cs;
      sbcs1 <= sb * cs;
      cbse1 <= cb * se;
      sbse1 <= sb * se;
      sb1   <= sb;
      cb1   <= cb;
    end
  end

  // Stage 2: reach and the length-weighted entries
  logic signed [LTT_W-1:0]  p12, p13, p22, p23;
  logic signed [R_W-1:0]    r2;
  logic signed [A_W-1:0]    a12_2, a13_2, a22_2, a23_2, a32_2, a33_2;
  logic signed [TRIG_W-1:0] sb2, cb2;

  always_comb begin
    p12 = a_s * cbcs1 + LTT_W'(1 << 29);
    p13 = b_s * cbse1 + LTT_W'(1 << 29);
    p22 = a_s * sbcs1 + LTT_W'(1 << 29);
    p23 = b_s * sbse1 + LTT_W'(1 << 29);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2    <= $signed(R_W'(base)) + $signed(R_W'(tool)) + R_W'(as1) - R_W'(bc1);
      a12_2 <= A_W'(p12 >>> 30);
      a13_2 <= A_W'(p13 >>> 30);
      a22_2 <= A_W'(p22 >>> 30);
      a23_2 <= A_W'(p23 >>> 30);
      a32_2 <= -as1;
      a33_2 <= -bc1;
      sb2   <= sb1;
      cb2   <= cb1;
    end
  end

  // Stage 3: reach-weighted entries
  logic signed [TR_W-1:0] p11, p21;
  logic signed [A_W-1:0]  a11_3, a12_3, a13_3, a21_3, a22_3, a23_3, a32_3, a33_3;

  always_comb begin
    p11 = sb2 * r2 + TR_W'(16384);
    p21 = cb2 * r2 + TR_W'(16384);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a11_3 <= -A_W'(p11 >>> 15);
      a21_3 <= A_W'(p21 >>> 15);
      a12_3 <= a12_2;
      a13_3 <= a13_2;
      a22_3 <= a22_2;
      a23_3 <= a23_2;
      a32_3 <= a32_2;
      a33_3 <= a33_2;
    end
  end

  // Stage 4: adjugate
  logic signed [COF_W-1:0] c11, c12, c13, c21, c22, c23, c31, c32, c33;
  logic signed [A_W-1:0]   a11_4, a12_4, a13_4;

  always_ff @(posedge clk) begin
    if (en) begin
      c11 <= COF_W'(a22_3 * a33_3) - COF_W'(a32_3 * a23_3);
      c12 <= COF_W'(a32_3 * a13_3) - COF_W'(a12_3 * a33_3);
      c13 <= COF_W'(a12_3 * a23_3) - COF_W'(a22_3 * a13_3);
      c21 <= -COF_W'(a21_3 * a33_3);
      c22 <= COF_W'(a11_3 * a33_3);
      c23 <= COF_W'(a21_3 * a13_3) - COF_W'(a11_3 * a23_3);
      c31 <= COF_W'(a21_3 * a32_3);
      c32 <= -COF_W'(a11_3 * a32_3);
      c33 <= COF_W'(a11_3 * a22_3) - COF_W'(a21_3 * a12_3);
      a11_4 <= a11_3;
      a12_4 <= a12_3;
      a13_4 <= a13_3;
    end
  end

  // Stage 5: determinant and numerator products
  logic signed [DP_W-1:0] d1, d2, d3;
  logic signed [NP_W-1:0] n11, n12, n13, n21, n22, n23, n31, n32, n33;
  logic signed [VEL_W-1:0] vx, vy, vz;

  assign vx = vxd[VD_LEN-1];
  assign vy = vyd[VD_LEN-1];
  assign vz = vzd[VD_LEN-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d1  <= a11_4 * c11;
      d2  <= a12_4 * c21;
      d3  <= a13_4 * c31;
      n11 <= c11 * vx;
      n12 <= c12 * vy;
      n13 <= c13 * vz;
      n21 <= c21 * vx;
      n22 <= c22 * vy;
      n23 <= c23 * vz;
      n31 <= c31 * vx;
      n32 <= c32 * vy;
      n33 <= c33 * vz;
    end
  end

  // Stage 6: sums
  logic signed [DET_W-1:0] det6;
  logic signed [NUM_W-1:0] num0, num1, num2;

  always_ff @(posedge clk) begin
    if (en) begin
      det6 <= DET_W'(d1) + DET_W'(d2) + DET_W'(d3);
      num0 <= NUM_W'(n11) + NUM_W'(n12) + NUM_W'(n13);
      num1 <= NUM_W'(n21) + NUM_W'(n22) + NUM_W'(n23);
      num2 <= NUM_W'(n31) + NUM_W'(n32) + NUM_W'(n33);
    end
  end

  // Singular flag rides next to the dividers
  logic [DIV_LAT-1:0] sing_d;

  always_ff @(posedge clk) begin
    if (en) begin
      sing_d <= {sing_d[DIV_LAT-2:0], (det6 == '0)};
    end
  end

  logic signed [RATE_W-1:0] q0, q1, q2;
  logic                     s0, s1, s2;

  ajrs_div u_div_base (.clk(clk), .en(en), .num(num0), .den(det6), .quo(q0), .sat(s0));
  ajrs_div u_div_shoulder (.clk(clk), .en(en), .num(num1), .den(det6), .quo(q1), .sat(s1));
  ajrs_div u_div_elbow (.clk(clk), .en(en), .num(num2), .den(det6), .quo(q2), .sat(s2));

  // Drop the rates on a singular pose
  assign singular      = sing_d[DIV_LAT-1];
  assign base_rate     = singular ? '0 : q0;
  assign shoulder_rate = singular ? '0 : q1;
  assign elbow_rate    = singular ? '0 : q2;
  assign saturated     = !singular && (s0 || s1 || s2);

endmodule

[verif/ajrs_checker.sv]
`timescale 1ns / 100ps

module ajrs_checker import ajrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [ANG_W-1:0]         base_angle,
  input  logic [ANG_W-1:0]         shoulder_angle,
  input  logic [ANG_W-1:0]         elbow_angle,
  input  logic signed [VEL_W-1:0]  vel_x,
  input  logic signed [VEL_W-1:0]  vel_y,
  input  logic signed [VEL_W-1:0]  vel_z,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [RATE_W-1:0] base_rate,
  input  logic signed [RATE_W-1:0] shoulder_rate,
  input  logic signed [RATE_W-1:0] elbow_rate,
  input  logic                     singular,
  input  logic                     saturated,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [LEN_W-1:0]         cfg_data,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic signed [31:0] base_r;
    logic signed [31:0] shoulder_r;
    logic signed [31:0] elbow_r;
    logic               sing;
    logic               sat;
  } rates_t;

  rates_t rates_q[$];
  longint upper_len, fore_len, tool_len, base_len;

  // Arithmetic shift right with floor, on 64-bit values
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint atan_val(int i);
    longint tbl [24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  // CORDIC sine and cosine in Q1.15
  function automatic void trig(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] p;
    logic flip;
    longint x, y, z, nx;
    p = {ang, 16'h0} & (32'hFFFF_FFFF << (32 - ANGLE_BITS));
    flip = p[31] ^ p[30];
    if (flip) p[31] = ~p[31];
    z = longint'($signed(p));
    x = 652032874;
    y = 0;
    for (int i = 0; i < ANGLE_BITS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= atan_val(i);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += atan_val(i);
      end
      x = nx;
    end
    x = round_shift(x, 15);
    y = round_shift(y, 15);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Scaled quotient, truncated toward zero and clipped to 32 bits
  function automatic longint scaled_div(longint num, longint den, ref logic sat);
    logic neg;
    logic [63:0] n, d, q, r, lim;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = n / d;
    r = n % d;
    if (q < 64'h1_0000_0000) begin
      for (int i = 0; i < RATE_FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r -= d;
          q[0] = 1'b1;
        end
      end
    end
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic rates_t solve_rates(logic [15:0] ab, logic [15:0] as_, logic [15:0] ae,
                                         longint vx, longint vy, longint vz);
    longint sb, cb, ss, cs, se, ce, a, b, asn, bcs, r;
    longint j11, j12, j13, j21, j22, j23, j32, j33;
    longint c11, c12, c13, c21, c22, c23, c31, c32, c33, det;
    logic sat;
    rates_t res;
    trig(ab, sb, cb);
    trig(as_, ss, cs);
    trig(ae, se, ce);
    a = upper_len;
    b = fore_len;
    asn = round_shift(a * ss, 15);
    bcs = round_shift(b * ce, 15);
    r = base_len + tool_len + asn - bcs;
    j11 = -round_shift(sb * r, 15);
    j12 = round_shift(a * cb * cs, 30);
    j13 = round_shift(b * cb * se, 30);
    j21 = round_shift(cb * r, 15);
    j22 = round_shift(a * sb * cs, 30);
    j23 = round_shift(b * sb * se, 30);
    j32 = -asn;
    j33 = -bcs;
    c11 = j22 * j33 - j32 * j23;
    c12 = -(j12 * j33 - j32 * j13);
    c13 = j12 * j23 - j22 * j13;
    c21 = -(j21 * j33);
    c22 = j11 * j33;
    c23 = -(j11 * j23 - j21 * j13);
    c31 = j21 * j32;
    c32 = -(j11 * j32);
    c33 = j11 * j22 - j21 * j12;
    det = j11 * c11 + j12 * c21 + j13 * c31;
    sat = 1'b0;
    res = '0;
    // Singular pose gives zero rates and no clip flag
    if (det == 0) begin
      res.sing = 1'b1;
    end else begin
      res.base_r = 32'(scaled_div(c11 * vx + c12 * vy + c13 * vz, det, sat));
      res.shoulder_r = 32'(scaled_div(c21 * vx + c22 * vy + c23 * vz, det, sat));
      res.elbow_r = 32'(scaled_div(c31 * vx + c32 * vy + c33 * vz, det, sat));
      res.sat = sat;
    end
    return res;
  endfunction

  assign pending = rates_q.size();

  always @(posedge clk) begin
    rates_t exp_r;
    int errs;
    errs = 0;
    if (rst) begin
      upper_len <= UPPER_RST;
      fore_len <= FORE_RST;
      tool_len <= TOOL_RST;
      base_len <= BASE_RST;
      fail_count <= 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_UPPER: upper_len <= cfg_data;
          REG_FORE:  fore_len <= cfg_data;
          REG_TOOL:  tool_len <= cfg_data;
          REG_BASE:  base_len <= cfg_data;
          default: ;
        endcase
      end
      // Predict each accepted input word
      if (in_valid && !in_stall)
        rates_q.push_back(solve_rates(base_angle, shoulder_angle, elbow_angle,
                                      vel_x, vel_y, vel_z));
      // Compare each accepted output word
      if (out_valid && !out_stall) begin
        if (rates_q.size() == 0) begin
          $error("output word with no prediction");
          errs++;
        end else begin
          exp_r = rates_q.pop_front();
          if (exp_r.base_r !== base_rate) begin
            $error("base_rate exp %0d got %0d", exp_r.base_r, base_rate);
            errs++;
          end
          if (exp_r.shoulder_r !== shoulder_rate) begin
            $error("shoulder_rate exp %0d got %0d", exp_r.shoulder_r, shoulder_rate);
            errs++;
          end
          if (exp_r.elbow_r !== elbow_rate) begin
            $error("elbow_rate exp %0d got %0d", exp_r.elbow_r, elbow_rate);
            errs++;
          end
          if (exp_r.sing !== singular) begin
            $error("singular exp %0b got %0b", exp_r.sing, singular);
            errs++;
          end
          if (exp_r.sat !== saturated) begin
            $error("saturated exp %0b got %0b", exp_r.sat, saturated);
            errs++;
          end
        end
      end
      // Add up this cycle's mismatches
      if (errs != 0)
        fail_count <= fail_count + errs;
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import ajrs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic [ANG_W-1:0] base_angle = '0, shoulder_angle = '0, elbow_angle = '0;
  logic signed [VEL_W-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic signed [RATE_W-1:0] base_rate, shoulder_rate, elbow_rate;
  logic singular, saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  logic calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  arm_joint_rate_solver uut (.*);
  ajrs_checker chk (.*);

  // Random output stall, off during calm stretches
  always @(negedge clk)
    out_stall <= !calm && ($urandom_range(99) < 11);

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Hold valid after acceptance; the next word or an idle cycle replaces it
  task automatic send_word(logic [15:0] ab, logic [15:0] as_, logic [15:0] ae,
                           logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    base_angle <= ab;
    shoulder_angle <= as_;
    elbow_angle <= ae;
    vel_x <= vx;
    vel_y <= vy;
    vel_z <= vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LEN + 10) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    logic [15:0] quads [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                               16'h2000, 16'hFFFF, 16'h0001, 16'h7FFF};
    return ($urandom_range(3) == 0) ? quads[$urandom_range(7)] : 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_vel();
    logic [15:0] edges [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    return ($urandom_range(7) == 0) ? edges[$urandom_range(3)] : 16'($urandom);
  endfunction

  task automatic random_words(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i % 200) >= 150;
      send_word(pick_angle(), pick_angle(), pick_angle(), pick_vel(), pick_vel(), pick_vel());
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [15:0] lens [4];
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes of angles and velocities at reset lengths
    send_word(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(16'h4000, 16'h4000, 16'h4000, 16'h8000, 16'h8000, 16'h8000);
    send_word(16'h8000, 16'hC000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000);
    send_word(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(16'h2000, 16'h1000, 16'hE000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(16'h0001, 16'h8000, 16'h4000, 16'h0001, 16'hFFFF, 16'h0001);
    send_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    random_words(500);
    drain();

    // Zero lengths: singular poses everywhere
    write_reg(REG_UPPER, 16'h0000);
    write_reg(REG_FORE, 16'h0000);
    write_reg(REG_TOOL, 16'h0000);
    write_reg(REG_BASE, 16'h0000);
    send_word(16'h1234, 16'h4000, 16'h8000, 16'h7FFF, 16'h8000, 16'h1111);
    random_words(100);
    drain();

    // Largest lengths
    write_reg(REG_UPPER, 16'hFFFF);
    write_reg(REG_FORE, 16'hFFFF);
    write_reg(REG_TOOL, 16'hFFFF);
    write_reg(REG_BASE, 16'hFFFF);
    random_words(250);
    drain();

    // Tiny lengths drive rates into clipping
    write_reg(REG_UPPER, 16'h0001);
    write_reg(REG_FORE, 16'h0002);
    write_reg(REG_TOOL, 16'h0000);
    write_reg(REG_BASE, 16'h0001);
    random_words(200);
    drain();

    // Random length settings
    for (int k = 0; k < 3; k++) begin
      foreach (lens[j]) lens[j] = 16'($urandom);
      write_reg(REG_UPPER, lens[0]);
      write_reg(REG_FORE, lens[1]);
      write_reg(REG_TOOL, lens[2]);
      write_reg(REG_BASE, lens[3]);
      random_words(200);
      drain();
    end

    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
